[rtl/oftem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// oftem_pkg
// Shared constants, types and helper functions of the off-screen target
// edge marker pipeline.
// ---------------------------------------------------------------------------
package oftem_pkg;

    // fixed point formats
    localparam int FRAC_BITS       = 16;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int ONE             = 1 << FRAC_BITS;
    localparam int EPS             = (ONE + 5000) / 10000;
    localparam int EDGE_PAD        = 12;
    localparam int CORDIC_STEPS    = 30;

    // port widths
    localparam int CLIP_W     = 32;
    localparam int SCR_W      = 13;
    localparam int MRK_W      = 11;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = SCR_W;
    localparam int MPOS_W     = 17;
    localparam int ANG_W      = 16;
    localparam int IN_TD_W    = 4 * CLIP_W;
    localparam int OUT_FLD_W  = 2 * MPOS_W + ANG_W;
    localparam int OUT_TD_W   = ((OUT_FLD_W + 7) / 8) * 8;

    // vector length
    localparam int SQ_W       = 2 * CLIP_W;
    localparam int LEN_W      = CLIP_W;

    // unit direction: |d| <= ONE
    localparam int D_W        = FRAC_BITS + 2;
    localparam int DMAG_W     = FRAC_BITS + 1;
    localparam int DIR_NUM_W  = CLIP_W + FRAC_BITS;
    localparam int DIR_Q_W    = FRAC_BITS + 1;

    // per-axis scale: half extent / |d|, divisor known above EPS
    localparam int SC_NUM_W   = SCR_W + 2 * FRAC_BITS - 1;
    localparam int SC_Q_W     = SC_NUM_W - ($clog2(EPS + 2) - 1);
    localparam int S_LO_W     = SC_Q_W / 2;
    localparam int S_HI_W     = SC_Q_W - S_LO_W;
    localparam int PROD_W     = DMAG_W + SC_Q_W;
    localparam int OFF_W      = PROD_W - FRAC_BITS;
    localparam int POS_W      = OFF_W + 2;
    localparam int POS_SHIFT  = FRAC_BITS - 4;
    localparam int MPOS_MAX   = (1 << MPOS_W) - 1;

    // angle unit (Q30 radians)
    localparam int CXY_W      = 34;
    localparam int CZ_W       = 35;
    localparam int CORDIC_SHIFT = 30 - FRAC_BITS;
    localparam int ANG_SHIFT  = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [CZ_W-1:0] PI_Q30      = CZ_W'(64'sd3373259426);
    localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = CZ_W'(64'sd1686629713);
    localparam logic signed [CZ_W-1:0] TWO_PI_Q30  = CZ_W'(64'sd6746518852);
    localparam logic signed [CZ_W-1:0] ANG_ROUND   = CZ_W'(64'sd1 <<< (ANG_SHIFT - 1));

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_SCREEN_W = 2'd0,
        CFG_SCREEN_H = 2'd1,
        CFG_MARKER_W = 2'd2,
        CFG_MARKER_H = 2'd3
    } t_cfg_reg;

    // carried through the square root
    typedef struct packed {
        logic              hide;
        logic              xneg;
        logic              yneg;
        logic [CLIP_W-1:0] ax;
        logic [CLIP_W-1:0] ay;
        logic [CLIP_W-1:0] aw;
    } t_root_sb;

    // carried through the direction divider
    typedef struct packed {
        logic hide;
        logic degen;
        logic xneg;
        logic yneg;
    } t_quo_sb;

    // unit direction word
    typedef struct packed {
        logic                  hide;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic                  infx;
        logic                  infy;
    } t_dir_sb;

    // direction plus finished angle
    typedef struct packed {
        t_dir_sb          dir;
        logic [ANG_W-1:0] ang;
    } t_scl_sb;

    // magnitude of a direction component
    function automatic logic [DMAG_W-1:0] f_dmag(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] m;
        m = d[D_W-1] ? -d : d;
        return m[DMAG_W-1:0];
    endfunction

    // arctan(2^-i) in Q30
    function automatic logic signed [CZ_W-1:0] f_atan(input int i);
        logic signed [CZ_W-1:0] a;
        case (i)
            0:  a = CZ_W'(843314857);
            1:  a = CZ_W'(497837829);
            2:  a = CZ_W'(263043837);
            3:  a = CZ_W'(133525159);
            4:  a = CZ_W'(67021687);
            5:  a = CZ_W'(33543516);
            6:  a = CZ_W'(16775851);
            7:  a = CZ_W'(8388437);
            8:  a = CZ_W'(4194283);
            9:  a = CZ_W'(2097149);
            default: a = CZ_W'(64'sd1 <<< (30 - i));
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[rtl/oftem_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// oftem_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word that travels alongside.
// ---------------------------------------------------------------------------
module oftem_isqrt #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32,
    parameter int SB_W  = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [IN_W-1:0]  i_rad,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_root,
    output logic [SB_W-1:0]       o_sb
);

    logic              r_v    [OUT_W];
    logic [OUT_W+1:0]  r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [IN_W-1:0]   r_rad  [OUT_W];
    logic [SB_W-1:0]   r_sb   [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic             s_v;
        logic [OUT_W+1:0] s_rem;
        logic [OUT_W-1:0] s_root;
        logic [IN_W-1:0]  s_rad;
        logic [SB_W-1:0]  s_sb;
        logic [OUT_W+1:0] s_t;
        logic [OUT_W+1:0] s_trial;

        if (k == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
            assign s_sb   = i_sb;
        end else begin : g_next
            assign s_v    = r_v[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_sb   = r_sb[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign s_t     = {s_rem[OUT_W-1:0], s_rad[IN_W-1 -: 2]};
        assign s_trial = {s_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_t >= s_trial) begin
                    r_rem[k]  <= s_t - s_trial;
                    r_root[k] <= {s_root[OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= s_t;
                    r_root[k] <= {s_root[OUT_W-2:0], 1'b0};
                end
                r_rad[k] <= {s_rad[IN_W-3:0], 2'b00};
                r_sb[k]  <= s_sb;
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_sb    = r_sb[OUT_W-1];

endmodule
`default_nettype wire

[rtl/oftem_div2.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// oftem_div2
// Two-lane pipelined restoring divider, one quotient bit per stage.
// The dividend's top part above Q_W bits must be below the divisor.
// ---------------------------------------------------------------------------
module oftem_div2 #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 17,
    parameter int SB_W  = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num_a,
    input  wire logic [DEN_W-1:0] i_den_a,
    input  wire logic [NUM_W-1:0] i_num_b,
    input  wire logic [DEN_W-1:0] i_den_b,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [Q_W-1:0]        o_quo_a,
    output logic [Q_W-1:0]        o_quo_b,
    output logic [SB_W-1:0]       o_sb
);

    // one step: returns {remainder, shifted work word with new quotient bit}
    function automatic logic [DEN_W+Q_W-1:0] f_step(
        input logic [DEN_W-1:0] rem,
        input logic [Q_W-1:0]   wk,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t = {rem, wk[Q_W-1]};
        if (t >= {1'b0, den}) begin
            d = t - {1'b0, den};
            return {d[DEN_W-1:0], wk[Q_W-2:0], 1'b1};
        end else begin
            return {t[DEN_W-1:0], wk[Q_W-2:0], 1'b0};
        end
    endfunction

    logic             r_v     [Q_W];
    logic [DEN_W-1:0] r_rem_a [Q_W];
    logic [DEN_W-1:0] r_rem_b [Q_W];
    logic [Q_W-1:0]   r_wk_a  [Q_W];
    logic [Q_W-1:0]   r_wk_b  [Q_W];
    logic [DEN_W-1:0] r_den_a [Q_W];
    logic [DEN_W-1:0] r_den_b [Q_W];
    logic [SB_W-1:0]  r_sb    [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             s_v;
        logic [DEN_W-1:0] s_rem_a, s_rem_b, s_den_a, s_den_b;
        logic [Q_W-1:0]   s_wk_a, s_wk_b;
        logic [SB_W-1:0]  s_sb;

        if (k == 0) begin : g_first
            assign s_v     = i_valid;
            assign s_rem_a = DEN_W'(i_num_a >> Q_W);
            assign s_rem_b = DEN_W'(i_num_b >> Q_W);
            assign s_wk_a  = i_num_a[Q_W-1:0];
            assign s_wk_b  = i_num_b[Q_W-1:0];
            assign s_den_a = i_den_a;
            assign s_den_b = i_den_b;
            assign s_sb    = i_sb;
        end else begin : g_next
            assign s_v     = r_v[k-1];
            assign s_rem_a = r_rem_a[k-1];
            assign s_rem_b = r_rem_b[k-1];
            assign s_wk_a  = r_wk_a[k-1];
            assign s_wk_b  = r_wk_b[k-1];
            assign s_den_a = r_den_a[k-1];
            assign s_den_b = r_den_b[k-1];
            assign s_sb    = r_sb[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                {r_rem_a[k], r_wk_a[k]} <= f_step(s_rem_a, s_wk_a, s_den_a);
                {r_rem_b[k], r_wk_b[k]} <= f_step(s_rem_b, s_wk_b, s_den_b);
                r_den_a[k] <= s_den_a;
                r_den_b[k] <= s_den_b;
                r_sb[k]    <= s_sb;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo_a = r_wk_a[Q_W-1];
    assign o_quo_b = r_wk_b[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule
`default_nettype wire

[rtl/oftem_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// oftem_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians. One quadrant
// pre-rotation stage, then one micro-rotation per stage.
// ---------------------------------------------------------------------------
module oftem_cordic #(
    parameter int XY_W  = 34,
    parameter int Z_W   = 35,
    parameter int STEPS = 30,
    parameter int SB_W  = 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [XY_W-1:0] i_x,
    input  wire logic signed [XY_W-1:0] i_y,
    input  wire logic [SB_W-1:0]        i_sb,
    output logic                        o_valid,
    output logic signed [Z_W-1:0]       o_z,
    output logic [SB_W-1:0]             o_sb
);
    import oftem_pkg::*;

    logic                   r_v  [STEPS+1];
    logic signed [XY_W-1:0] r_x  [STEPS+1];
    logic signed [XY_W-1:0] r_y  [STEPS+1];
    logic signed [Z_W-1:0]  r_z  [STEPS+1];
    logic [SB_W-1:0]        r_sb [STEPS+1];

    // quadrant pre-rotation for a negative x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= Z_W'(HALF_PI_Q30);
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -Z_W'(HALF_PI_Q30);
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // micro-rotations toward y = 0
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam int SH = k - 1;
        logic signed [Z_W-1:0] s_atan;
        assign s_atan = Z_W'(f_atan(SH));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[k] <= r_sb[k-1];
                if (r_y[k-1] > 0) begin
                    r_x[k] <= r_x[k-1] + (r_y[k-1] >>> SH);
                    r_y[k] <= r_y[k-1] - (r_x[k-1] >>> SH);
                    r_z[k] <= r_z[k-1] + s_atan;
                end else begin
                    r_x[k] <= r_x[k-1] - (r_y[k-1] >>> SH);
                    r_y[k] <= r_y[k-1] + (r_x[k-1] >>> SH);
                    r_z[k] <= r_z[k-1] - s_atan;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_z     = r_z[STEPS];
    assign o_sb    = r_sb[STEPS];

endmodule
`default_nettype wire

[rtl/offscreen_target_edge_marker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// offscreen_target_edge_marker
// Edge marker placement for one off-screen target per word: visibility test,
// vector length, unit direction, marker angle and ray/rectangle clamp.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle unless a held output word stalls the
// whole pipeline; nothing is dropped. The chain is 32 square-root stages,
// 17 direction-divider stages, 31 CORDIC stages and 41 scale-divider stages.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration defaults 1280 x 720 screen, 64 x 64 marker.
module offscreen_target_edge_marker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [oftem_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [oftem_pkg::CFG_DW-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [oftem_pkg::IN_TD_W-1:0]   i_s_tdata,  // clip_x, clip_y, clip_z, clip_w
    input  wire logic                            i_s_tuser,  // target_enabled
    // output stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [oftem_pkg::OUT_TD_W-1:0]       o_m_tdata,  // marker_x, marker_y, marker_angle
    output logic                                 o_m_tuser   // visible
);
    import oftem_pkg::*;

    logic w_en;

    // ---------------- configuration registers ----------------
    logic [SCR_W-1:0] r_scr_w, r_scr_h;
    logic [MRK_W-1:0] r_mrk_w, r_mrk_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCR_W'(1280);
            r_scr_h <= SCR_W'(720);
            r_mrk_w <= MRK_W'(64);
            r_mrk_h <= MRK_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_SCREEN_W: r_scr_w <= i_cfg_wdata;
                CFG_SCREEN_H: r_scr_h <= i_cfg_wdata;
                CFG_MARKER_W: r_mrk_w <= i_cfg_wdata[MRK_W-1:0];
                CFG_MARKER_H: r_mrk_h <= i_cfg_wdata[MRK_W-1:0];
                default: ;
            endcase
        end
    end

    // margin and full extents of the inset rectangle (the scale numerator halves them)
    logic [MRK_W-1:0] w_mmax;
    logic [SCR_W-1:0] w_lim, w_half_x, w_half_y;
    logic             w_small;
    assign w_mmax   = (r_mrk_w > r_mrk_h) ? r_mrk_w : r_mrk_h;
    assign w_lim    = SCR_W'(w_mmax) + SCR_W'(2 * EDGE_PAD);
    assign w_small  = (r_scr_w <= w_lim) || (r_scr_h <= w_lim);
    assign w_half_x = r_scr_w - w_lim;
    assign w_half_y = r_scr_h - w_lim;

    // ---------------- stage F0: visibility test ----------------
    logic signed [CLIP_W-1:0] w_x, w_y, w_z, w_w;
    logic [CLIP_W-1:0]        w_ax, w_ay, w_aw;
    logic                     w_onscr;
    assign w_x  = $signed(i_s_tdata[0*CLIP_W +: CLIP_W]);
    assign w_y  = $signed(i_s_tdata[1*CLIP_W +: CLIP_W]);
    assign w_z  = $signed(i_s_tdata[2*CLIP_W +: CLIP_W]);
    assign w_w  = $signed(i_s_tdata[3*CLIP_W +: CLIP_W]);
    assign w_ax = w_x[CLIP_W-1] ? CLIP_W'(-w_x) : CLIP_W'(w_x);
    assign w_ay = w_y[CLIP_W-1] ? CLIP_W'(-w_y) : CLIP_W'(w_y);
    assign w_aw = w_w[CLIP_W-1] ? CLIP_W'(-w_w) : CLIP_W'(w_w);
    assign w_onscr = (w_w > 0) && (w_z >= 0) && (w_z <= w_w)
                  && (w_ax <= CLIP_W'(w_w)) && (w_ay <= CLIP_W'(w_w));

    logic     r_f0_v;
    t_root_sb r_f0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
        end else if (w_en) begin
            r_f0_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f0.hide <= !i_s_tuser || w_small || (w_aw <= CLIP_W'(EPS)) || w_onscr;
            r_f0.xneg <= w_x[CLIP_W-1];
            r_f0.yneg <= w_y[CLIP_W-1];
            r_f0.ax   <= w_ax;
            r_f0.ay   <= w_ay;
            r_f0.aw   <= w_aw;
        end
    end

    // ---------------- stage F1: squares ----------------
    logic            r_f1_v;
    t_root_sb        r_f1;
    logic [SQ_W-1:0] r_sqx, r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= r_f0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1  <= r_f0;
            r_sqx <= r_f0.ax * r_f0.ax;
            r_sqy <= r_f0.ay * r_f0.ay;
        end
    end

    // ---------------- stage F2: sum of squares ----------------
    logic            r_f2_v;
    t_root_sb        r_f2;
    logic [SQ_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2  <= r_f1;
            r_sum <= r_sqx + r_sqy;
        end
    end

    // ---------------- vector length ----------------
    logic             w_sq_v;
    logic [LEN_W-1:0] w_len;
    t_root_sb         w_sq_sb;

    oftem_isqrt #(
        .IN_W  (SQ_W),
        .OUT_W (LEN_W),
        .SB_W  ($bits(t_root_sb))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f2_v),
        .i_rad   (r_sum),
        .i_sb    (r_f2),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_sb    (w_sq_sb)
    );

    // ---------------- stage P1: degenerate test, divider operands ----------------
    logic [LEN_W+FRAC_BITS-1:0] w_len_sh, w_eps_aw;
    assign w_len_sh = {w_len, {FRAC_BITS{1'b0}}};
    assign w_eps_aw = (LEN_W+FRAC_BITS)'(w_sq_sb.aw) * (LEN_W+FRAC_BITS)'(EPS + 1);

    logic                 r_p1_v;
    t_quo_sb              r_p1;
    logic [DIR_NUM_W-1:0] r_p1_nx, r_p1_ny;
    logic [LEN_W-1:0]     r_p1_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1.hide  <= w_sq_sb.hide;
            r_p1.degen <= (w_len == '0) || (w_len_sh < w_eps_aw);
            r_p1.xneg  <= w_sq_sb.xneg;
            r_p1.yneg  <= w_sq_sb.yneg;
            r_p1_nx    <= {w_sq_sb.ax, {FRAC_BITS{1'b0}}};
            r_p1_ny    <= {w_sq_sb.ay, {FRAC_BITS{1'b0}}};
            r_p1_len   <= w_len;
        end
    end

    // ---------------- unit direction divider ----------------
    logic               w_q1_v;
    logic [DIR_Q_W-1:0] w_qx, w_qy;
    t_quo_sb            w_q1_sb;

    oftem_div2 #(
        .NUM_W (DIR_NUM_W),
        .DEN_W (LEN_W),
        .Q_W   (DIR_Q_W),
        .SB_W  ($bits(t_quo_sb))
    ) u_div_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p1_v),
        .i_num_a (r_p1_nx),
        .i_den_a (r_p1_len),
        .i_num_b (r_p1_ny),
        .i_den_b (r_p1_len),
        .i_sb    (r_p1),
        .o_valid (w_q1_v),
        .o_quo_a (w_qx),
        .o_quo_b (w_qy),
        .o_sb    (w_q1_sb)
    );

    // ---------------- stage P2: signed direction ----------------
    logic signed [D_W-1:0] w_qx_s, w_qy_s;
    assign w_qx_s = $signed({1'b0, w_qx});
    assign w_qy_s = $signed({1'b0, w_qy});

    logic    r_p2_v;
    t_dir_sb r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p2_v <= w_q1_v;
        end
    end

    // screen y grows downward, so dy takes the sign of -y; fallback is up
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2.hide <= w_q1_sb.hide;
            if (w_q1_sb.degen) begin
                r_p2.dx   <= '0;
                r_p2.dy   <= -D_W'(ONE);
                r_p2.infx <= 1'b1;
                r_p2.infy <= 1'b0;
            end else begin
                r_p2.dx   <= w_q1_sb.xneg ? -w_qx_s : w_qx_s;
                r_p2.dy   <= w_q1_sb.yneg ? w_qy_s : -w_qy_s;
                r_p2.infx <= (w_qx <= DIR_Q_W'(EPS));
                r_p2.infy <= (w_qy <= DIR_Q_W'(EPS));
            end
        end
    end

    // ---------------- marker angle ----------------
    logic signed [CXY_W-1:0] w_cx, w_cy;
    assign w_cx = CXY_W'(r_p2.dx) <<< CORDIC_SHIFT;
    assign w_cy = CXY_W'(r_p2.dy) <<< CORDIC_SHIFT;

    logic                   w_co_v;
    logic signed [CZ_W-1:0] w_z_ang;
    t_dir_sb                w_co_sb;

    oftem_cordic #(
        .XY_W  (CXY_W),
        .Z_W   (CZ_W),
        .STEPS (CORDIC_STEPS),
        .SB_W  ($bits(t_dir_sb))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p2_v),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_sb    (r_p2),
        .o_valid (w_co_v),
        .o_z     (w_z_ang),
        .o_sb    (w_co_sb)
    );

    // ---------------- stage A1: angle finish, scale operands ----------------
    logic signed [CZ_W-1:0] w_ang_raw, w_ang_cl, w_ang_rnd;
    always_comb begin
        w_ang_raw = w_z_ang - PI_Q30;
        if (w_ang_raw > 0) begin
            w_ang_cl = '0;
        end else if (w_ang_raw < -TWO_PI_Q30) begin
            w_ang_cl = -TWO_PI_Q30;
        end else begin
            w_ang_cl = w_ang_raw;
        end
        w_ang_rnd = (w_ang_cl + ANG_ROUND) >>> ANG_SHIFT;
    end

    logic                r_a1_v;
    t_scl_sb             r_a1;
    logic [SC_NUM_W-1:0] r_a1_nx, r_a1_ny;
    logic [DMAG_W-1:0]   r_a1_mx, r_a1_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0;
        end else if (w_en) begin
            r_a1_v <= w_co_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1.dir <= w_co_sb;
            r_a1.ang <= w_ang_rnd[ANG_W-1:0];
            r_a1_nx  <= {w_half_x, {(2*FRAC_BITS-1){1'b0}}};
            r_a1_ny  <= {w_half_y, {(2*FRAC_BITS-1){1'b0}}};
            r_a1_mx  <= f_dmag(w_co_sb.dx);
            r_a1_my  <= f_dmag(w_co_sb.dy);
        end
    end

    // ---------------- per-axis scale divider ----------------
    logic              w_q2_v;
    logic [SC_Q_W-1:0] w_sx, w_sy;
    t_scl_sb           w_q2_sb;

    oftem_div2 #(
        .NUM_W (SC_NUM_W),
        .DEN_W (DMAG_W),
        .Q_W   (SC_Q_W),
        .SB_W  ($bits(t_scl_sb))
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a1_v),
        .i_num_a (r_a1_nx),
        .i_den_a (r_a1_mx),
        .i_num_b (r_a1_ny),
        .i_den_b (r_a1_my),
        .i_sb    (r_a1),
        .o_valid (w_q2_v),
        .o_quo_a (w_sx),
        .o_quo_b (w_sy),
        .o_sb    (w_q2_sb)
    );

    // ---------------- stage S: pick the nearer edge ----------------
    logic              r_s_v;
    t_scl_sb           r_s_sb;
    logic [SC_Q_W-1:0] r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_en) begin
            r_s_v <= w_q2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_sb <= w_q2_sb;
            if (w_q2_sb.dir.infx && w_q2_sb.dir.infy) begin
                r_s <= '0;
            end else if (w_q2_sb.dir.infx) begin
                r_s <= w_sy;
            end else if (w_q2_sb.dir.infy) begin
                r_s <= w_sx;
            end else begin
                r_s <= (w_sx < w_sy) ? w_sx : w_sy;
            end
        end
    end

    // ---------------- stage M1: partial products ----------------
    logic                     r_m1_v;
    t_scl_sb                  r_m1_sb;
    logic [DMAG_W+S_LO_W-1:0] r_m1_lox, r_m1_loy;
    logic [DMAG_W+S_HI_W-1:0] r_m1_hix, r_m1_hiy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (w_en) begin
            r_m1_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_sb  <= r_s_sb;
            r_m1_lox <= f_dmag(r_s_sb.dir.dx) * r_s[S_LO_W-1:0];
            r_m1_hix <= f_dmag(r_s_sb.dir.dx) * r_s[SC_Q_W-1:S_LO_W];
            r_m1_loy <= f_dmag(r_s_sb.dir.dy) * r_s[S_LO_W-1:0];
            r_m1_hiy <= f_dmag(r_s_sb.dir.dy) * r_s[SC_Q_W-1:S_LO_W];
        end
    end

    // ---------------- stage M2: signed offsets ----------------
    logic [PROD_W-1:0] w_prod_x, w_prod_y;
    logic [OFF_W-1:0]  w_mag_x, w_mag_y;
    assign w_prod_x = PROD_W'(r_m1_lox) + (PROD_W'(r_m1_hix) << S_LO_W);
    assign w_prod_y = PROD_W'(r_m1_loy) + (PROD_W'(r_m1_hiy) << S_LO_W);
    assign w_mag_x  = w_prod_x[PROD_W-1:FRAC_BITS];
    assign w_mag_y  = w_prod_y[PROD_W-1:FRAC_BITS];

    logic                    r_m2_v;
    logic                    r_m2_hide;
    logic [ANG_W-1:0]        r_m2_ang;
    logic signed [POS_W-1:0] r_m2_offx, r_m2_offy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (w_en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_hide <= r_m1_sb.dir.hide;
            r_m2_ang  <= r_m1_sb.ang;
            r_m2_offx <= r_m1_sb.dir.dx[D_W-1] ? -$signed(POS_W'(w_mag_x))
                                               :  $signed(POS_W'(w_mag_x));
            r_m2_offy <= r_m1_sb.dir.dy[D_W-1] ? -$signed(POS_W'(w_mag_y))
                                               :  $signed(POS_W'(w_mag_y));
        end
    end

    // ---------------- output register: position, clamp ----------------
    function automatic logic [MPOS_W-1:0] f_pos(
        input logic [SCR_W-1:0]        size,
        input logic signed [POS_W-1:0] off
    );
        logic signed [POS_W-1:0] p;
        logic signed [POS_W-1:0] sh;
        p  = $signed(POS_W'({size, {(FRAC_BITS-1){1'b0}}})) + off;
        sh = p >>> POS_SHIFT;
        if (p < 0) begin
            return '0;
        end else if (sh > POS_W'(MPOS_MAX)) begin
            return MPOS_W'(MPOS_MAX);
        end else begin
            return sh[MPOS_W-1:0];
        end
    endfunction

    logic              r_out_v;
    logic              r_out_vis;
    logic [MPOS_W-1:0] r_out_x, r_out_y;
    logic [ANG_W-1:0]  r_out_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_vis <= !r_m2_hide;
            if (r_m2_hide) begin
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_ang <= '0;
            end else begin
                r_out_x   <= f_pos(r_scr_w, r_m2_offx);
                r_out_y   <= f_pos(r_scr_h, r_m2_offy);
                r_out_ang <= r_m2_ang;
            end
        end
    end

    // whole pipeline advances unless the output word is held
    assign w_en       = !r_out_v || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_vis;
    assign o_m_tdata  = OUT_TD_W'({r_out_ang, r_out_y, r_out_x});

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stream testbench for the off-screen target edge marker. A queue of clip
// space targets feeds a clocked driver; a clocked monitor compares every
// output word with the marker predicted by a behavioral copy of the math.
// ---------------------------------------------------------------------------
module tb_top;
    import oftem_pkg::*;

    localparam int N_RANDOM   = 1330;
    localparam int DRAIN_CYC  = 300;
    localparam longint PI_L   = 64'sd3373259426;
    localparam longint HPI_L  = 64'sd1686629713;

    typedef struct {
        logic        enabled;
        logic [31:0] cx, cy, cz, cw;
    } t_target;

    typedef struct {
        logic        visible;
        logic [16:0] mx, my;
        logic [15:0] angle;
    } t_marker;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_TD_W-1:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_TD_W-1:0] o_m_tdata;
    logic o_m_tuser;

    offscreen_target_edge_marker dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers
    longint scr_w = 1280, scr_h = 720, mrk_w = 64, mrk_h = 64;

    t_target pending_targets[$];
    t_marker expected_markers[$];
    bit      n_fail = 0;
    bit      calm = 0;     // stretch with no idling

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint cordic_atan2(longint yy, longint xx);
        longint z = 0, t, nx, ny, a;
        if (xx < 0) begin
            if (yy >= 0) begin
                t = xx; xx = yy; yy = -t; z = HPI_L;
            end else begin
                t = xx; xx = -yy; yy = t; z = -HPI_L;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            a = longint'(f_atan(i));
            if (yy > 0) begin
                nx = xx + sra(yy, i); ny = yy - sra(xx, i); z += a;
            end else begin
                nx = xx - sra(yy, i); ny = yy + sra(xx, i); z -= a;
            end
            xx = nx; yy = ny;
        end
        return z;
    endfunction

    function automatic t_marker place_marker(t_target t);
        t_marker m = '{1'b0, '0, '0, '0};
        longint one = 64'sd1 << FRAC_BITS;
        longint eps = EPS;
        longint x, y, z, w, aw, len, ndc, dx, dy, hx, hy, sx, sy, s, px, py, ang, mm;
        bit ix, iy;
        if (!t.enabled) return m;
        mm = (mrk_w > mrk_h) ? mrk_w : mrk_h;
        if (scr_w <= mm + 2 * EDGE_PAD || scr_h <= mm + 2 * EDGE_PAD) return m;
        x = longint'(signed'(t.cx)); y = longint'(signed'(t.cy));
        z = longint'(signed'(t.cz)); w = longint'(signed'(t.cw));
        aw = w < 0 ? -w : w;
        if (aw <= eps) return m;
        if (w > 0 && z >= 0 && z <= w && (x < 0 ? -x : x) <= w && (y < 0 ? -y : y) <= w)
            return m;
        len = isqrt(longint'(x * x) + longint'(y * y));
        ndc = (len * one) / aw;
        if (ndc <= eps || len == 0) begin
            dx = 0; dy = -one;
        end else begin
            dx = (x * one) / len; dy = (-y * one) / len;
        end
        hx = ((scr_w - mm - 2 * EDGE_PAD) * one) / 2;
        hy = ((scr_h - mm - 2 * EDGE_PAD) * one) / 2;
        ix = (dx < 0 ? -dx : dx) <= eps;
        iy = (dy < 0 ? -dy : dy) <= eps;
        sx = ix ? 0 : (hx * one) / (dx < 0 ? -dx : dx);
        sy = iy ? 0 : (hy * one) / (dy < 0 ? -dy : dy);
        if (ix && iy) s = 0;
        else if (ix) s = sy;
        else if (iy) s = sx;
        else s = sx < sy ? sx : sy;
        px = (scr_w * one) / 2 + (dx * s) / one;
        py = (scr_h * one) / 2 + (dy * s) / one;
        px = px < 0 ? 0 : (px >>> (FRAC_BITS - 4));
        py = py < 0 ? 0 : (py >>> (FRAC_BITS - 4));
        if (px > MPOS_MAX) px = MPOS_MAX;
        if (py > MPOS_MAX) py = MPOS_MAX;
        ang = cordic_atan2(dy <<< CORDIC_SHIFT, dx <<< CORDIC_SHIFT) - PI_L;
        if (ang > 0) ang = 0;
        if (ang < -2 * PI_L) ang = -2 * PI_L;
        ang = sra(ang + (64'sd1 <<< (ANG_SHIFT - 1)), ANG_SHIFT);
        m.visible = 1'b1;
        m.mx = px[16:0];
        m.my = py[16:0];
        m.angle = ang[15:0];
        return m;
    endfunction

    // driver: one target word per handshake
    always @(posedge i_clk) begin
        t_target t;
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_targets.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
                    t = pending_targets.pop_front();
                    expected_markers.push_back(place_marker(t));
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {t.cw, t.cz, t.cy, t.cx};
                    i_s_tuser  <= t.enabled;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= calm || ($urandom_range(99) >= 35);
        end
    end

    // monitor: compare each output word against the oldest prediction
    always @(posedge i_clk) begin
        t_marker e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_markers.size() == 0) begin
                $error("unexpected output word");
                n_fail = 1;
            end else begin
                e = expected_markers.pop_front();
                if (o_m_tuser !== e.visible) begin
                    $error("visible exp %0d got %0d", e.visible, o_m_tuser);
                    n_fail = 1;
                end
                if (o_m_tdata[16:0] !== e.mx) begin
                    $error("marker_x exp %0d got %0d", e.mx, o_m_tdata[16:0]);
                    n_fail = 1;
                end
                if (o_m_tdata[33:17] !== e.my) begin
                    $error("marker_y exp %0d got %0d", e.my, o_m_tdata[33:17]);
                    n_fail = 1;
                end
                if (o_m_tdata[49:34] !== e.angle) begin
                    $error("marker_angle exp %0d got %0d", $signed(e.angle),
                           $signed(o_m_tdata[49:34]));
                    n_fail = 1;
                end
            end
        end
    end

    task automatic add_target(logic en, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] w);
        pending_targets.push_back('{en, x, y, z, w});
    endtask

    task automatic write_reg(t_cfg_reg idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SCREEN_W: scr_w = val & 32'h1FFF;
            CFG_SCREEN_H: scr_h = val & 32'h1FFF;
            CFG_MARKER_W: mrk_w = val & 32'h7FF;
            default:      mrk_h = val & 32'h7FF;
        endcase
    endtask

    task automatic drain();
        while (pending_targets.size() != 0 || expected_markers.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // random target, mostly off screen, sometimes on screen or behind
    task automatic add_random_target();
        logic [31:0] w, x, y, z;
        int kind;
        kind = $urandom_range(9);
        w = $urandom_range(1 << 20, 1);
        case (kind)
            0: begin
                x = $urandom; y = $urandom; z = $urandom; w = $urandom;
            end
            1: begin
                x = $urandom_range(w); y = $urandom_range(w); z = $urandom_range(w);
            end
            2: begin
                x = $urandom_range(15) - 8; y = $urandom_range(15) - 8;
                z = -w; w = -w;
            end
            3: begin
                x = -$urandom_range(1 << 22); y = $urandom_range(1 << 22);
                z = $urandom; w = -w;
            end
            default: begin
                x = $urandom_range(1 << 23) - (1 << 22);
                y = $urandom_range(1 << 23) - (1 << 22);
                z = $urandom_range(1 << 22) - (1 << 20);
            end
        endcase
        if ($urandom_range(9) == 0) w = $urandom_range(14) - 7;
        add_target($urandom_range(19) != 0, x, y, z, w);
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes and special cases at reset geometry
        add_target(1'b0, 32'h7FFF_FFFF, 0, 0, 32'h0001_0000);            // disabled
        add_target(1'b1, 0, 0, 32'h0000_8000, 32'h0001_0000);            // on screen
        add_target(1'b1, 32'h0002_0000, 0, 0, 32'h0001_0000);            // right edge
        add_target(1'b1, 32'hFFFE_0000, 0, 0, 32'h0001_0000);            // left edge
        add_target(1'b1, 0, 32'h0002_0000, 0, 32'h0001_0000);            // top
        add_target(1'b1, 0, 32'hFFFE_0000, 0, 32'h0001_0000);            // bottom
        add_target(1'b1, 32'h0001_0000, 32'h0001_0000, 0, 32'hFFFF_0000); // behind
        add_target(1'b1, 0, 0, 0, 32'hFFFF_0000);                         // degenerate dir
        add_target(1'b1, 32'h10, 32'h10, 0, 7);                           // tiny w
        add_target(1'b1, 32'h10, 32'h10, 0, 8);
        add_target(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_target(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_target(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0100);
        add_target(1'b1, 0, 0, 32'hFFFF_FFFF, 32'h0001_0000);            // z below near
        add_target(1'b1, 0, 0, 32'h0001_0001, 32'h0001_0000);            // z beyond far
        add_target(1'b1, 32'hFFFE_0000, 32'h0000_0001, 0, 32'h0001_0000); // angle near -2pi
        drain();
        write_reg(CFG_MARKER_W, 1024);                                    // screen too small
        add_target(1'b1, 32'h0002_0000, 0, 0, 32'h0001_0000);
        drain();

        // random phases through several geometries, the extremes among them
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SCREEN_W, 1280); write_reg(CFG_SCREEN_H, 720);
                    write_reg(CFG_MARKER_W, 64);   write_reg(CFG_MARKER_H, 64);
                end
                1: begin
                    write_reg(CFG_SCREEN_W, 8191); write_reg(CFG_SCREEN_H, 8191);
                    write_reg(CFG_MARKER_W, 1);    write_reg(CFG_MARKER_H, 1);
                end
                2: begin
                    write_reg(CFG_SCREEN_W, 0);    write_reg(CFG_SCREEN_H, 0);
                end
                3: begin
                    write_reg(CFG_SCREEN_W, 8191); write_reg(CFG_SCREEN_H, 8191);
                    write_reg(CFG_MARKER_W, 2047); write_reg(CFG_MARKER_H, 0);
                end
                4: begin
                    write_reg(CFG_SCREEN_W, 26);   write_reg(CFG_SCREEN_H, 26);
                    write_reg(CFG_MARKER_W, 1);    write_reg(CFG_MARKER_H, 0);
                end
                default: begin
                    write_reg(CFG_SCREEN_W, $urandom_range(8191));
                    write_reg(CFG_SCREEN_H, $urandom_range(8191));
                    write_reg(CFG_MARKER_W, $urandom_range(2047));
                    write_reg(CFG_MARKER_H, $urandom_range(1024, 1));
                end
            endcase
            calm = (phase == 5);
            repeat (N_RANDOM / 8) add_random_target();
            drain();
        end
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(4 * 200000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
